// ===== rtl/scfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the serial command frame parser.
// Used by the parser, the output queue and the top level; depends on nothing.
package scfp_pkg;

	localparam logic [7:0] START_FIRST_RST  = 8'h73;
	localparam logic [7:0] START_SECOND_RST = 8'h32;
	localparam logic [7:0] MAX_PAYLOAD      = 8'd255;
	localparam logic [7:0] RESP_BASE        = 8'h80;

	// Register indexes of the configuration port.
	localparam logic REG_START_FIRST  = 1'b0;
	localparam logic REG_START_SECOND = 1'b1;

	// Command codes.
	localparam logic [7:0] CMD_PING       = 8'h00;
	localparam logic [7:0] CMD_SESS_START = 8'h01;
	localparam logic [7:0] CMD_SESS_END   = 8'h02;
	localparam logic [7:0] CMD_TWO_A      = 8'h03;
	localparam logic [7:0] CMD_TRANSMIT   = 8'h04;
	localparam logic [7:0] CMD_ZERO_A     = 8'h06;
	localparam logic [7:0] CMD_ZERO_B     = 8'h07;
	localparam logic [7:0] CMD_TWO_B      = 8'h09;
	localparam logic [7:0] CMD_TWO_C      = 8'h0a;
	localparam logic [7:0] CMD_ONE_A      = 8'h0b;

	localparam logic [1:0] PCNT_UNKNOWN = 2'd3;

	// Depth of the result queue; must be at least two.
	localparam int OUT_DEPTH = 4;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_START2 = 5'b00010,
		PH_CMD    = 5'b00100,
		PH_PARAMS = 5'b01000,
		PH_DATA   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] command;
		logic [7:0] param_first;
		logic [7:0] param_second;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       handled;
		logic [7:0] response_code;
		logic       session_open;
		logic       last;
	} result_t;

	// Up to two results written to the queue in one cycle.
	typedef struct packed {
		logic    v0;
		result_t r0;
		logic    v1;
		result_t r1;
	} push_t;

	function automatic logic [1:0] param_count(input logic [7:0] cmd);
		logic [1:0] n;
		case (cmd) inside
			CMD_PING, CMD_SESS_START, CMD_SESS_END, CMD_ZERO_A, CMD_ZERO_B: n = 2'd0;
			CMD_TRANSMIT, CMD_ONE_A:                                       n = 2'd1;
			CMD_TWO_A, CMD_TWO_B, CMD_TWO_C:                               n = 2'd2;
			default:                                                       n = PCNT_UNKNOWN;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/scfp_parser.sv =====
`timescale 1ns / 1ps
// Frame parser: input byte register, start code hunt, command and parameter
// decode, and generation of payload and completion results. Uses scfp_pkg.
module scfp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	output logic              in_ready,
	input  logic              room2,
	output scfp_pkg::push_t   push
);

	logic [7:0] start_first_q, start_second_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;

	scfp_pkg::phase_t phase_q, phase_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] p0_q, p0_d, p1_q, p1_d;
	logic [1:0] needed_q, needed_d, seen_q, seen_d;
	logic [7:0] length_q, length_d, pseen_q, pseen_d;
	logic       open_q, open_d;

	logic [1:0] n_cnt, seen_n;
	logic [7:0] p0_n, p1_n, pseen_n;

	function automatic logic open_after(input logic [7:0] cmd, input logic open_in);
		logic o;
		o = open_in;
		if (cmd == scfp_pkg::CMD_PING || cmd == scfp_pkg::CMD_SESS_START) begin
			o = 1'b1;
		end else if (cmd == scfp_pkg::CMD_SESS_END) begin
			o = 1'b0;
		end
		return o;
	endfunction

	function automatic scfp_pkg::result_t make_result(input logic kind, input logic [7:0] cmd,
			input logic [1:0] needed, input logic [7:0] p0, input logic [7:0] p1,
			input logic open_in);
		scfp_pkg::result_t r;
		logic h;
		r = '0;
		h = cmd == scfp_pkg::CMD_PING || cmd == scfp_pkg::CMD_SESS_START ||
			cmd == scfp_pkg::CMD_SESS_END || cmd == scfp_pkg::CMD_TRANSMIT;
		r.item_kind    = kind;
		r.command      = cmd;
		r.param_first  = (needed >= 2'd1) ? p0 : 8'd0;
		r.param_second = (needed >= 2'd2) ? p1 : 8'd0;
		r.session_open = open_in;
		if (kind) begin
			r.handled       = h;
			r.response_code = h ? cmd + scfp_pkg::RESP_BASE : 8'd0;
			r.session_open  = open_after(cmd, open_in);
			r.last          = 1'b1;
		end
		return r;
	endfunction

	// The byte in the input register is parsed once the queue can take two results.
	assign fire     = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= scfp_pkg::START_FIRST_RST;
			start_second_q <= scfp_pkg::START_SECOND_RST;
		end else if (cfg_we) begin
			if (cfg_index == scfp_pkg::REG_START_FIRST) begin
				start_first_q <= cfg_wdata;
			end else begin
				start_second_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		cmd_d    = cmd_q;
		p0_d     = p0_q;
		p1_d     = p1_q;
		needed_d = needed_q;
		seen_d   = seen_q;
		length_d = length_q;
		pseen_d  = pseen_q;
		open_d   = open_q;
		push     = '0;
		n_cnt    = scfp_pkg::param_count(byte_s1);
		seen_n   = seen_q + 2'd1;
		p0_n     = seen_q[0] ? p0_q : byte_s1;
		p1_n     = seen_q[0] ? byte_s1 : p1_q;
		pseen_n  = pseen_q + 8'd1;
		if (fire) begin
			case (phase_q)
				scfp_pkg::PH_START2: begin
					if (byte_s1 == start_second_q) begin
						phase_d = scfp_pkg::PH_CMD;
					end else begin
						phase_d = scfp_pkg::PH_IDLE;
						seen_d  = 2'd0;
						pseen_d = 8'd0;
					end
				end
				scfp_pkg::PH_CMD: begin
					cmd_d  = byte_s1;
					seen_d = 2'd0;
					if (n_cnt == scfp_pkg::PCNT_UNKNOWN) begin
						needed_d = 2'd0;
						phase_d  = scfp_pkg::PH_IDLE;
						pseen_d  = 8'd0;
					end else if (n_cnt == 2'd0) begin
						needed_d = 2'd0;
						phase_d  = scfp_pkg::PH_IDLE;
						pseen_d  = 8'd0;
						push.v0  = 1'b1;
						push.r0  = make_result(1'b1, byte_s1, 2'd0, p0_q, p1_q, open_q);
						open_d   = open_after(byte_s1, open_q);
					end else begin
						needed_d = n_cnt;
						phase_d  = scfp_pkg::PH_PARAMS;
					end
				end
				scfp_pkg::PH_PARAMS: begin
					p0_d   = p0_n;
					p1_d   = p1_n;
					seen_d = seen_n;
					if (seen_n >= needed_q) begin
						length_d = p0_n;
						pseen_d  = 8'd0;
						if (p0_n == 8'd0) begin
							// Empty payload: the frame completes on its last parameter.
							phase_d = scfp_pkg::PH_IDLE;
							seen_d  = 2'd0;
							push.v0 = 1'b1;
							push.r0 = make_result(1'b1, cmd_q, needed_q, p0_n, p1_n, open_q);
							open_d  = open_after(cmd_q, open_q);
						end else if (p0_n > scfp_pkg::MAX_PAYLOAD) begin
							phase_d = scfp_pkg::PH_IDLE;
							seen_d  = 2'd0;
						end else begin
							phase_d = scfp_pkg::PH_DATA;
						end
					end
				end
				scfp_pkg::PH_DATA: begin
					push.v0               = 1'b1;
					push.r0               = make_result(1'b0, cmd_q, needed_q, p0_q, p1_q,
						open_q);
					push.r0.payload_byte  = byte_s1;
					push.r0.payload_index = pseen_q;
					if (pseen_n == length_q) begin
						// Last payload byte also closes the frame.
						phase_d = scfp_pkg::PH_IDLE;
						seen_d  = 2'd0;
						pseen_d = 8'd0;
						push.v1 = 1'b1;
						push.r1 = make_result(1'b1, cmd_q, needed_q, p0_q, p1_q, open_q);
						open_d  = open_after(cmd_q, open_q);
					end else begin
						pseen_d      = pseen_n;
						push.r0.last = 1'b1;
					end
				end
				default: begin
					if (byte_s1 == start_first_q) begin
						phase_d = scfp_pkg::PH_START2;
					end else begin
						phase_d = scfp_pkg::PH_IDLE;
						seen_d  = 2'd0;
						pseen_d = 8'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scfp_pkg::PH_IDLE;
			cmd_q    <= 8'd0;
			p0_q     <= 8'd0;
			p1_q     <= 8'd0;
			needed_q <= 2'd0;
			seen_q   <= 2'd0;
			length_q <= 8'd0;
			pseen_q  <= 8'd0;
			open_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			p0_q     <= p0_d;
			p1_q     <= p1_d;
			needed_q <= needed_d;
			seen_q   <= seen_d;
			length_q <= length_d;
			pseen_q  <= pseen_d;
			open_q   <= open_d;
		end
	end

endmodule

// ===== rtl/scfp_out_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per request.
// Uses scfp_pkg for the result and push types.
module scfp_out_fifo #(
	parameter int DEPTH = scfp_pkg::OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scfp_pkg::push_t                push,
	output logic                           room2,
	output logic                           out_valid,
	input  logic                           out_ready,
	output scfp_pkg::result_t              out_data,
	output logic [$clog2(DEPTH + 1) - 1:0] level
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	scfp_pkg::result_t mem_q [DEPTH];
	logic [PTR_W - 1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CNT_W - 1:0] count_q;
	logic               pop;

	function automatic logic [PTR_W - 1:0] inc(input logic [PTR_W - 1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1  = inc(wr_ptr_q);
	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign room2     = count_q <= CNT_W'(DEPTH - 2);
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.v0 && push.v1) begin
				wr_ptr_q <= inc(wr_ptr_1);
			end else if (push.v0) begin
				wr_ptr_q <= wr_ptr_1;
			end
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/serial_command_frame_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the serial command frame parser: parser and result queue.
// Depends on scfp_pkg, scfp_parser and scfp_out_fifo.

// The block takes one host link byte per clock while the input register is
// free or the result queue has room for two more results. A byte is held in
// an input register and parsed once the queue has that room; its results
// (none, one, or a payload item followed by a completion item) are written
// to a small result queue, which registers them before they appear on the
// output. With a consumer that keeps tready high the rate is one byte per
// cycle.
// The start code bytes may be rewritten through the cfg port while idle.
module serial_command_frame_parser_top #(
	parameter int OUT_DEPTH = scfp_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// command[7:0], param_first[15:8], param_second[23:16], payload_byte[31:24],
	// payload_index[39:32], handled[40], response_code[48:41], session_open[49], zero
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tuser,   // item_kind
	output logic        m_axis_tlast    // last
);

	scfp_pkg::push_t   push;
	scfp_pkg::result_t head;
	logic              room2;
	logic [$clog2(OUT_DEPTH + 1) - 1:0] level;

	scfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_ready  (s_axis_tready),
		.room2     (room2),
		.push      (push)
	);

	scfp_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (head),
		.level     (level)
	);

	assign m_axis_tdata = {6'd0, head.session_open, head.response_code, head.handled,
		head.payload_index, head.payload_byte, head.param_second, head.param_first,
		head.command};
	assign m_axis_tuser = head.item_kind;
	assign m_axis_tlast = head.last;

	// The queue never holds more results than it has entries.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= ($clog2(OUT_DEPTH + 1))'(OUT_DEPTH))
		else $error("result queue overflow");

	// A second result in one cycle only follows a first one.
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result without first");

	// A byte that yields two results gives a payload item, then the final completion.
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (!push.r0.item_kind && !push.r0.last &&
			push.r1.item_kind && push.r1.last))
		else $error("malformed result pair");

	// Output valid tracks a non-empty queue.
	a_valid_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid == (level != '0))
		else $error("output valid does not match queue level");

endmodule

// ===== test/scfp_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the serial command frame parser: follows the start code writes and the
// accepted bytes, predicts every result and compares it with what the block delivers.
// Depends on scfp_pkg for the result layout, the command codes and the reset values.
module scfp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// command[7:0], param_first[15:8], param_second[23:16], payload_byte[31:24],
	// payload_index[39:32], handled[40], response_code[48:41], session_open[49], zero
	input  logic [55:0] m_axis_tdata,
	input  logic        m_axis_tuser,   // item_kind
	input  logic        m_axis_tlast,   // last
	output int          fail_count,
	output int          pending
);

	typedef enum logic [4:0] {
		HUNT    = 5'b00001,
		SECOND  = 5'b00010,
		OPCODE  = 5'b00100,
		PARAMS  = 5'b01000,
		PAYLOAD = 5'b10000
	} stage_t;

	stage_t            stage;
	logic [7:0]        code_first;
	logic [7:0]        code_second;
	logic [7:0]        cmd;
	logic [7:0]        prm [2];
	logic [1:0]        prm_need;
	logic [1:0]        prm_got;
	logic [7:0]        pay_len;
	logic [7:0]        pay_pos;
	logic              session;
	scfp_pkg::result_t due_results [$];

	// Parameter bytes a command takes; negative for a command with no table entry.
	function automatic int param_bytes(input logic [7:0] c);
		case (c)
			scfp_pkg::CMD_PING, scfp_pkg::CMD_SESS_START, scfp_pkg::CMD_SESS_END,
			scfp_pkg::CMD_ZERO_A, scfp_pkg::CMD_ZERO_B:               return 0;
			scfp_pkg::CMD_TRANSMIT, scfp_pkg::CMD_ONE_A:              return 1;
			scfp_pkg::CMD_TWO_A, scfp_pkg::CMD_TWO_B, scfp_pkg::CMD_TWO_C: return 2;
			default:                                                  return -1;
		endcase
	endfunction

	function automatic scfp_pkg::result_t frame_base(input logic kind);
		scfp_pkg::result_t r;
		r = '0;
		r.item_kind    = kind;
		r.command      = cmd;
		r.param_first  = (prm_need >= 2'd1) ? prm[0] : 8'h00;
		r.param_second = (prm_need >= 2'd2) ? prm[1] : 8'h00;
		r.session_open = session;
		return r;
	endfunction

	task automatic push_completion();
		scfp_pkg::result_t r;
		logic              has_handler;
		has_handler = (cmd == scfp_pkg::CMD_PING) || (cmd == scfp_pkg::CMD_SESS_START) ||
			(cmd == scfp_pkg::CMD_SESS_END) || (cmd == scfp_pkg::CMD_TRANSMIT);
		if (cmd == scfp_pkg::CMD_PING || cmd == scfp_pkg::CMD_SESS_START)
			session = 1'b1;
		else if (cmd == scfp_pkg::CMD_SESS_END)
			session = 1'b0;
		r = frame_base(1'b1);
		r.handled       = has_handler;
		r.response_code = has_handler ? cmd + scfp_pkg::RESP_BASE : 8'h00;
		r.last          = 1'b1;
		due_results.push_back(r);
	endtask

	task automatic parse_byte(input logic [7:0] b);
		scfp_pkg::result_t r;
		int                n;
		case (stage)
			// A wrong second byte is dropped, never retried as a first byte.
			SECOND: stage = (b == code_second) ? OPCODE : HUNT;
			OPCODE: begin
				cmd = b;
				prm_got = 2'd0;
				n = param_bytes(b);
				if (n < 0) begin
					prm_need = 2'd0;
					stage = HUNT;
				end else begin
					prm_need = n[1:0];
					if (n == 0) begin
						stage = HUNT;
						push_completion();
					end else begin
						stage = PARAMS;
					end
				end
			end
			PARAMS: begin
				prm[prm_got[0]] = b;
				prm_got = prm_got + 2'd1;
				if (prm_got >= prm_need) begin
					pay_len = prm[0];
					pay_pos = 8'd0;
					if (pay_len == 8'd0) begin
						stage = HUNT;
						push_completion();
					end else begin
						stage = PAYLOAD;
					end
				end
			end
			PAYLOAD: begin
				r = frame_base(1'b0);
				r.payload_byte  = b;
				r.payload_index = pay_pos;
				pay_pos = pay_pos + 8'd1;
				if (pay_pos == pay_len) begin
					// The closing byte gives the payload item and then the completion.
					stage = HUNT;
					due_results.push_back(r);
					push_completion();
				end else begin
					r.last = 1'b1;
					due_results.push_back(r);
				end
			end
			default: stage = (b == code_first) ? SECOND : HUNT;
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input scfp_pkg::result_t got);
		scfp_pkg::result_t want;
		if (due_results.size() == 0) begin
			$error("result with none expected: item_kind %0h command %0h",
				got.item_kind, got.command);
			fail_count++;
			return;
		end
		want = due_results.pop_front();
		check_field("item_kind", 8'(want.item_kind), 8'(got.item_kind));
		check_field("command", want.command, got.command);
		check_field("param_first", want.param_first, got.param_first);
		check_field("param_second", want.param_second, got.param_second);
		check_field("payload_byte", want.payload_byte, got.payload_byte);
		check_field("payload_index", want.payload_index, got.payload_index);
		check_field("handled", 8'(want.handled), 8'(got.handled));
		check_field("response_code", want.response_code, got.response_code);
		check_field("session_open", 8'(want.session_open), 8'(got.session_open));
		check_field("last", 8'(want.last), 8'(got.last));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		scfp_pkg::result_t seen;
		if (!arst_n) begin
			stage       = HUNT;
			code_first  = scfp_pkg::START_FIRST_RST;
			code_second = scfp_pkg::START_SECOND_RST;
			cmd         = 8'h00;
			prm[0]      = 8'h00;
			prm[1]      = 8'h00;
			prm_need    = 2'd0;
			prm_got     = 2'd0;
			pay_len     = 8'd0;
			pay_pos     = 8'd0;
			session     = 1'b0;
			due_results.delete();
			fail_count  = 0;
			pending    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.item_kind     = m_axis_tuser;
				seen.command       = m_axis_tdata[7:0];
				seen.param_first   = m_axis_tdata[15:8];
				seen.param_second  = m_axis_tdata[23:16];
				seen.payload_byte  = m_axis_tdata[31:24];
				seen.payload_index = m_axis_tdata[39:32];
				seen.handled       = m_axis_tdata[40];
				seen.response_code = m_axis_tdata[48:41];
				seen.session_open  = m_axis_tdata[49];
				seen.last          = m_axis_tlast;
				check_result(seen);
			end
			if (cfg_we) begin
				if (cfg_index == scfp_pkg::REG_START_FIRST)
					code_first = cfg_wdata;
				else
					code_second = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata);
			pending <= due_results.size();
		end
	end

endmodule

// ===== test/serial_command_frame_parser_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the serial command frame parser: clock, reset, byte and frame
// stimulus, start code changes, receiver stalls and the verdict.
// Depends on scfp_pkg, serial_command_frame_parser_top and scfp_frame_checker.
module serial_command_frame_parser_top_test;

	localparam int FRAME_BYTES_PER_CODE = 320;
	localparam int STALL_LIMIT          = 2000;
	// Commands outside the parameter table.
	localparam logic [7:0] UNLISTED_A    = 8'h05;
	localparam logic [7:0] UNLISTED_B    = 8'h08;
	localparam logic [7:0] UNLISTED_FROM = 8'h0c;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending;

	logic [7:0]  start_a = scfp_pkg::START_FIRST_RST;
	logic [7:0]  start_b = scfp_pkg::START_SECOND_RST;
	logic        send_quiet = 1'b0;
	logic        take_quiet = 1'b0;
	int          take_hold = 0;
	int          idle_cycles = 0;

	always #2 clk = ~clk;

	serial_command_frame_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	scfp_frame_checker u_frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// After each accepted result the receiver holds off for a random number of cycles,
	// except in quiet stretches where it takes every cycle.
	always @(posedge clk or negedge arst_n) begin : take_side
		int draw;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			take_hold <= 0;
		end else if (m_axis_tready && m_axis_tvalid) begin
			draw = take_quiet ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 31) == 0)
				take_quiet <= !take_quiet;
			m_axis_tready <= (draw == 0);
			take_hold <= draw;
		end else if (!m_axis_tready) begin
			if (take_hold <= 1)
				m_axis_tready <= 1'b1;
			take_hold <= take_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Holds one byte request until it is taken; valid stays high into the next byte
	// when no gap is drawn.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 11);
		if ($urandom_range(0, 31) == 0)
			send_quiet = !send_quiet;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_frame(input logic [7:0] c, input int nprm, input logic [7:0] len,
		input logic [7:0] p2);
		send_byte(start_a);
		send_byte(start_b);
		send_byte(c);
		if (nprm >= 1)
			send_byte(len);
		if (nprm >= 2)
			send_byte(p2);
		if (nprm >= 1)
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic set_start_code(input logic [7:0] a, input logic [7:0] b);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// The last byte may still be in the input register with nothing to show for it.
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= scfp_pkg::REG_START_FIRST;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_index <= scfp_pkg::REG_START_SECOND;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_a = a;
		start_b = b;
	endtask

	// Mostly well-formed frames with random content, mixed with unknown commands,
	// broken start codes and line noise. Every byte sent counts toward the quota.
	task automatic random_traffic(input int quota);
		int         sent;
		int         pick;
		int         n;
		logic [7:0] c;
		logic [7:0] len;
		logic [7:0] b;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				case ($urandom_range(0, 9))
					0: begin c = scfp_pkg::CMD_PING;       n = 0; end
					1: begin c = scfp_pkg::CMD_SESS_START; n = 0; end
					2: begin c = scfp_pkg::CMD_SESS_END;   n = 0; end
					3: begin c = scfp_pkg::CMD_ZERO_A;     n = 0; end
					4: begin c = scfp_pkg::CMD_ZERO_B;     n = 0; end
					5: begin c = scfp_pkg::CMD_TRANSMIT;   n = 1; end
					6: begin c = scfp_pkg::CMD_ONE_A;      n = 1; end
					7: begin c = scfp_pkg::CMD_TWO_A;      n = 2; end
					8: begin c = scfp_pkg::CMD_TWO_B;      n = 2; end
					default: begin c = scfp_pkg::CMD_TWO_C; n = 2; end
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 70)
					len = 8'($urandom_range(0, 4));
				else if (pick < 95)
					len = 8'($urandom_range(5, 20));
				else
					len = 8'($urandom_range(0, 255));
				send_frame(c, n, len, 8'($urandom_range(0, 255)));
				sent += 3 + n + ((n > 0) ? len : 0);
			end else if (pick < 85) begin
				if ($urandom_range(0, 3) == 0)
					c = $urandom_range(0, 1) ? UNLISTED_A : UNLISTED_B;
				else
					c = 8'($urandom_range(UNLISTED_FROM, 255));
				send_frame(c, 0, 8'h00, 8'h00);
				sent += 3;
			end else if (pick < 95) begin
				n = $urandom_range(1, 6);
				repeat (n)
					send_byte(8'($urandom_range(0, 255)));
				sent += n;
			end else begin
				b = 8'($urandom_range(0, 255));
				send_byte(start_a);
				send_byte((b == start_b) ? ~b : b);
				sent += 2;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Open; a two-parameter frame whose payload holds both byte extremes;
		// a one-parameter frame with zero length; an unknown command; a bad second
		// start byte followed by the real second byte, which must not restart the
		// hunt; then close and ping.
		send_frame(scfp_pkg::CMD_SESS_START, 0, 8'h00, 8'h00);
		send_byte(start_a);
		send_byte(start_b);
		send_byte(scfp_pkg::CMD_TWO_C);
		send_byte(8'h02);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(8'hff);
		send_frame(scfp_pkg::CMD_ONE_A, 1, 8'h00, 8'h00);
		send_frame(8'hff, 0, 8'h00, 8'h00);
		send_byte(start_a);
		send_byte(start_a);
		send_byte(start_b);
		send_byte(scfp_pkg::CMD_SESS_END);
		send_frame(scfp_pkg::CMD_SESS_END, 0, 8'h00, 8'h00);
		send_frame(scfp_pkg::CMD_PING, 0, 8'h00, 8'h00);

		random_traffic(FRAME_BYTES_PER_CODE);
		set_start_code(8'h00, 8'hff);
		random_traffic(FRAME_BYTES_PER_CODE);
		set_start_code(8'hff, 8'h00);
		random_traffic(FRAME_BYTES_PER_CODE);
		set_start_code(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_traffic(FRAME_BYTES_PER_CODE);
		// Equal start bytes: the second one must not be taken as a fresh first byte.
		set_start_code(8'h55, 8'h55);
		random_traffic(FRAME_BYTES_PER_CODE);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
